// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file lca_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored during reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle, ignored during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked also in reset.
`define ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/lca_pkg.sv =====
package lca_pkg;

   localparam int ROWS = 32;
   localparam int COLS = 32;

   localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int StepW = $clog2(ROWS + 2);
   localparam logic [StepW-1:0] LastStep = StepW'(ROWS + 1);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_ADVANCE = 2'd2;

   typedef logic [COLS-1:0] row_word_type;

   typedef struct packed {
      logic latch_req;
      logic fetch;
      logic use_word;
      logic sweep;
      logic [StepW-1:0] step;
      logic load_rsp;
   } ctrl_cmd_type;

   // Next generation of one row from the old rows above, at and below it.
   function automatic row_word_type life_row(row_word_type up, row_word_type mid,
                                             row_word_type dn);
      logic [COLS+1:0] u;
      logic [COLS+1:0] m;
      logic [COLS+1:0] d;
      logic [3:0] count;
      row_word_type res;
      u = {1'b0, up, 1'b0};
      m = {1'b0, mid, 1'b0};
      d = {1'b0, dn, 1'b0};
      res = '0;
      for (int c = 0; c < COLS; c++) begin
         count = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2])
               + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
         res[c] = (count == 4'd3) || (m[c+1] && (count == 4'd2));
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/lca_ram.sv =====
module lca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lca_ctrl.sv =====
module lca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_ready,
   input  logic                  rsp_free,
   output lca_pkg::ctrl_cmd_type cmd
);
   import lca_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_FETCH,
      S_USE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = (req_command == CMD_ADVANCE) ? S_SWEEP : S_FETCH;
            end
         end
         S_SWEEP: begin
            if (step_ff == LastStep) begin
               state_in = S_FETCH;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         S_FETCH: state_in = S_USE;
         S_USE: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.latch_req = (state_ff == S_IDLE) && req_valid;
      cmd.fetch = (state_ff == S_FETCH);
      cmd.use_word = (state_ff == S_USE);
      cmd.sweep = (state_ff == S_SWEEP);
      cmd.step = step_ff;
      cmd.load_rsp = (state_ff == S_DONE) && rsp_free;
   end

endmodule

// ===== rtl/core/lca_dp.sv =====
module lca_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_command,
   input  logic [4:0]            req_row,
   input  logic [4:0]            req_col,
   input  logic                  req_alive_in,
   input  lca_pkg::ctrl_cmd_type cmd,
   output logic                  rsp_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_cell_alive
);
   import lca_pkg::*;

   logic [1:0] command_ff;
   logic [4:0] row_ff;
   logic [4:0] col_ff;
   logic alive_ff;
   row_word_type up_ff, up_in;
   row_word_type mid_ff, mid_in;
   logic valid_ff [ROWS];
   logic rd_valid_ff, rd_valid_in;
   logic result_ff, result_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_cell_alive_ff;

   logic on_grid;
   logic [RowW-1:0] row_idx;
   logic rd_en;
   logic [RowW-1:0] rd_addr;
   row_word_type rd_data;
   row_word_type rd_word;
   row_word_type below;
   row_word_type shifted;
   row_word_type bit_mask;
   logic wr_en;
   logic [RowW-1:0] wr_addr;
   row_word_type wr_data;

   assign on_grid = (32'(row_ff) < ROWS) && (32'(col_ff) < COLS);
   assign row_idx = RowW'(row_ff);

   assign rd_en = cmd.fetch || (cmd.sweep && (32'(cmd.step) < ROWS));
   assign rd_addr = cmd.sweep ? RowW'(cmd.step) : row_idx;
   assign rd_valid_in = (32'(rd_addr) < ROWS) && valid_ff[rd_addr];
   assign rd_word = rd_valid_ff ? rd_data : '0;
   assign below = (32'(cmd.step) <= ROWS) ? rd_word : '0;

   assign shifted = rd_word >> col_ff;
   assign bit_mask = {{(COLS-1){1'b0}}, 1'b1} << col_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = row_idx;
      wr_data = alive_ff ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
      up_in = up_ff;
      mid_in = mid_ff;
      result_in = result_ff;
      if (cmd.sweep) begin
         if (cmd.step == '0) begin
            up_in = '0;
            mid_in = '0;
         end else begin
            up_in = mid_ff;
            mid_in = below;
         end
         if (cmd.step >= StepW'(2)) begin
            wr_en = 1'b1;
            wr_addr = RowW'(cmd.step - StepW'(2));
            wr_data = life_row(up_ff, mid_ff, below);
         end
      end
      if (cmd.use_word) begin
         if (command_ff == CMD_WRITE) begin
            wr_en = on_grid;
            result_in = on_grid && alive_ff;
         end else begin
            result_in = on_grid && shifted[0];
         end
      end
   end

   lca_ram #(
      .WIDTH(COLS),
      .DEPTH(ROWS)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         command_ff <= req_command;
         row_ff <= req_row;
         col_ff <= req_col;
         alive_ff <= req_alive_in;
      end
      if (rd_en) begin
         rd_valid_ff <= rd_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_cell_alive_ff <= result_ff;
      end
      up_ff <= up_in;
      mid_ff <= mid_in;
      result_ff <= result_in;
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_alive = rsp_cell_alive_ff;

endmodule

// ===== rtl/core/life_cellular_automaton_step.sv =====
// Life grid engine, rule B3/S23, on a ROWS by COLS grid of one-bit cells.
// The request channel carries a command (write cell, read cell, advance one
// generation), a row, a column and the value to write. Every request gives
// exactly one response transfer holding the addressed cell after the
// operation; an address outside the grid reads as dead and writes nothing.
// Requests are taken one at a time. For a read or write the request passes
// through the fetch, use and done states before the result is loaded into
// the response register, and the next request can be taken on the edge on
// which that response transfers. A generation sweeps the grid memory one row
// word per cycle through a three-row window, in ROWS + 2 sweep steps behind
// the registered memory read, then fetches and uses the addressed row.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits. If the receiver stalls and the register
// is full, the engine holds its result and takes no new request.
// Reset marks every row unwritten, so the whole grid reads as dead.
module life_cellular_automaton_step (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [4:0] req_row,
   input  logic [4:0] req_col,
   input  logic       req_alive_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_cell_alive
);
   import lca_pkg::*;

   ctrl_cmd_type cmd;
   logic rsp_free;

   lca_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_command(req_command),
      .req_ready(req_ready),
      .rsp_free(rsp_free),
      .cmd(cmd)
   );

   lca_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_command(req_command),
      .req_row(req_row),
      .req_col(req_col),
      .req_alive_in(req_alive_in),
      .cmd(cmd),
      .rsp_free(rsp_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_alive(rsp_cell_alive)
   );

endmodule

// ===== rtl/core/lca_checker.sv =====
`include "assert_macros.svh"

module lca_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_command,
   input logic [4:0] req_row,
   input logic [4:0] req_col,
   input logic       req_alive_in,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_cell_alive
);
   import lca_pkg::*;

   logic req_xfer;
   logic wr_xfer;

   assign req_xfer = req_valid && req_ready;
   assign wr_xfer = req_xfer && (req_command == CMD_WRITE) && !rsp_valid
                  && (32'(req_row) < ROWS) && (32'(req_col) < COLS);

   `ASSERT_ALWAYS_NEXT(a_reset_idle, reset, req_ready && !rsp_valid)
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_alive))
   `ASSERT_NEXT(a_one_at_a_time, req_xfer, !req_ready)
   `ASSERT_IMPL(a_write_echo, wr_xfer, ##4 (rsp_valid && rsp_cell_alive == $past(req_alive_in, 4)))

endmodule

bind life_cellular_automaton_step lca_checker u_lca_checker (.*);

// ===== verif/life_checker.sv =====
module life_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [4:0] req_row,
   input  logic [4:0] req_col,
   input  logic       req_alive_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_cell_alive,
   output int         errors,
   output int         pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import lca_pkg::*;

   typedef struct {
      logic       alive;
      logic [1:0] command;
      int         row;
      int         col;
   } cell_expect_type;

   row_word_type    board [ROWS];
   cell_expect_type expected_cells [$];

   function automatic logic board_cell(int r, int c);
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) begin
         return 1'b0;
      end
      return board[r][c];
   endfunction

   function automatic void next_generation();
      row_word_type nxt [ROWS];
      int           neighbors;
      for (int r = 0; r < ROWS; r++) begin
         nxt[r] = '0;
         for (int c = 0; c < COLS; c++) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     neighbors += int'(board_cell(r + dr, c + dc));
                  end
               end
            end
            if (board_cell(r, c)) begin
               nxt[r][c] = (neighbors == 2) || (neighbors == 3);
            end else begin
               nxt[r][c] = (neighbors == 3);
            end
         end
      end
      for (int r = 0; r < ROWS; r++) begin
         board[r] = nxt[r];
      end
   endfunction

   function automatic cell_expect_type apply_request(logic [1:0] command, int row, int col,
                                                     logic alive_in);
      cell_expect_type item;
      logic            on_grid;
      on_grid = (row < ROWS) && (col < COLS);
      if (command == CMD_WRITE) begin
         if (on_grid) begin
            board[row][col] = alive_in;
         end
      end else if (command == CMD_ADVANCE) begin
         next_generation();
      end
      item.alive = on_grid ? board[row][col] : 1'b0;
      item.command = command;
      item.row = row;
      item.col = col;
      return item;
   endfunction

   always @(posedge clock) begin
      cell_expect_type want;
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            board[r] = '0;
         end
         expected_cells.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: response transfer with nothing expected, expected none actual %0b",
                        $time, rsp_cell_alive);
               errors++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_cell_alive !== want.alive) begin
                  $display({"%0t: cell_alive mismatch (command %0d row %0d col %0d), ",
                            "expected %0b actual %0b"},
                           $time, want.command, want.row, want.col, want.alive,
                           rsp_cell_alive);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_cells.push_back(apply_request(req_command, int'(req_row), int'(req_col),
                                                   req_alive_in));
         end
      end
      pending <= expected_cells.size();
   end

endmodule

// ===== verif/tb_life_cellular_automaton_step.sv =====
module tb_life_cellular_automaton_step;

   timeunit 1ns;
   timeprecision 1ps;

   import lca_pkg::*;

   localparam logic [1:0] CmdSpare = 2'd3;
   localparam int CycleLimit = 500000;
   localparam int RandomItems = 1650;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_command;
   logic [4:0] req_row;
   logic [4:0] req_col;
   logic       req_alive_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_cell_alive;

   int errors;
   int pending;
   int idle_pct = 0;
   int stall_left = 0;
   int cycles = 0;
   int sent = 0;

   life_cellular_automaton_step dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_alive_in   (req_alive_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_alive (rsp_cell_alive)
   );

   life_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_alive_in   (req_alive_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_alive (rsp_cell_alive),
      .errors         (errors),
      .pending        (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Called at a clock edge; returns at the edge on which the transfer happens.
   task automatic send_item(logic [1:0] command, logic [4:0] row, logic [4:0] col,
                            logic alive_in);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_row <= row;
      req_col <= col;
      req_alive_in <= alive_in;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   initial begin
      int sz;
      int r0;
      int c0;
      int steps;
      int kind;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_READ;
      req_row <= '0;
      req_col <= '0;
      req_alive_in <= 1'b0;
      rsp_ready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Corners, the spare command code and isolated cells dying.
      send_item(CMD_READ, 5'd0, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd0, 5'd0, 1'b1);
      send_item(CMD_READ, 5'd0, 5'd0, 1'b0);
      send_item(CMD_WRITE, 5'd31, 5'd31, 1'b1);
      send_item(CMD_WRITE, 5'd0, 5'd31, 1'b1);
      send_item(CMD_WRITE, 5'd31, 5'd0, 1'b1);
      send_item(CmdSpare, 5'd31, 5'd31, 1'b0);
      send_item(CMD_ADVANCE, 5'd0, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd31, 5'd31, 1'b0);
      // A blinker in the middle of the grid.
      send_item(CMD_WRITE, 5'd10, 5'd9, 1'b1);
      send_item(CMD_WRITE, 5'd10, 5'd10, 1'b1);
      send_item(CMD_WRITE, 5'd10, 5'd11, 1'b1);
      send_item(CMD_ADVANCE, 5'd9, 5'd10, 1'b0);
      send_item(CMD_ADVANCE, 5'd10, 5'd10, 1'b0);
      send_item(CMD_READ, 5'd11, 5'd10, 1'b0);
      // A still block in the top left corner.
      send_item(CMD_WRITE, 5'd0, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd0, 5'd1, 1'b1);
      send_item(CMD_WRITE, 5'd1, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd1, 5'd1, 1'b1);
      send_item(CMD_ADVANCE, 5'd0, 5'd0, 1'b0);
      // A blinker on the left edge must not reach around to the right edge.
      send_item(CMD_WRITE, 5'd5, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd6, 5'd0, 1'b1);
      send_item(CMD_WRITE, 5'd7, 5'd0, 1'b1);
      send_item(CMD_ADVANCE, 5'd6, 5'd31, 1'b0);
      send_item(CMD_READ, 5'd6, 5'd1, 1'b0);
      send_item(CMD_WRITE, 5'd6, 5'd0, 1'b0);

      while (sent < RandomItems) begin
         if (sent > RandomItems - 150) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 10;
               2: idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // Fill a window with a random pattern, then let it evolve.
            sz = $urandom_range(3, 6);
            r0 = $urandom_range(0, 32 - sz);
            c0 = $urandom_range(0, 32 - sz);
            for (int r = 0; r < sz; r++) begin
               for (int c = 0; c < sz; c++) begin
                  send_item(CMD_WRITE, 5'(r0 + r), 5'(c0 + c), $urandom_range(0, 9) < 4);
               end
            end
            steps = $urandom_range(1, 4);
            for (int s = 0; s < steps; s++) begin
               send_item(CMD_ADVANCE, 5'(r0 + $urandom_range(0, sz - 1)),
                         5'(c0 + $urandom_range(0, sz - 1)), 1'($urandom_range(0, 1)));
               repeat ($urandom_range(0, 3)) begin
                  send_item(($urandom_range(0, 7) == 0) ? CmdSpare : CMD_READ,
                            5'(r0 + $urandom_range(0, sz - 1)),
                            5'(c0 + $urandom_range(0, sz - 1)), 1'($urandom_range(0, 1)));
               end
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
